@@ hdl/postfix_stack_evaluator_defines.svh @@
// Assertion macros for the postfix stack evaluator.
// Included by the top level; needs no other file.
`ifndef POSTFIX_STACK_EVALUATOR_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_DEFINES_SVH
`ifndef ASSERT_OFF
// Checks that a condition holds at every clock edge out of reset.
`define PSE_ASSERT(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);
// Checks that a condition in one cycle implies another in the next cycle.
`define PSE_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);
`else
`define PSE_ASSERT(name, clk, rst_n, expr, msg)
`define PSE_ASSERT_NEXT(name, clk, rst_n, pre, post, msg)
`endif
`endif

@@ hdl/pse_pkg.sv @@
// Shared types and constants of the postfix stack evaluator.
// Used by the interfaces, the divider and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package pse_pkg;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int WORD_W = 32;
    localparam int NUM_W = 31;
    localparam int OP_W = 5;
    localparam int ST_W = 3;

    // Operator codes.
    localparam logic [OP_W-1:0] OP_NOT = 5'd0;
    localparam logic [OP_W-1:0] OP_INC = 5'd1;
    localparam logic [OP_W-1:0] OP_DEC = 5'd2;
    localparam logic [OP_W-1:0] OP_NEG = 5'd3;
    localparam logic [OP_W-1:0] OP_POW = 5'd4;
    localparam logic [OP_W-1:0] OP_MUL = 5'd5;
    localparam logic [OP_W-1:0] OP_DIV = 5'd6;
    localparam logic [OP_W-1:0] OP_REM = 5'd7;
    localparam logic [OP_W-1:0] OP_ADD = 5'd8;
    localparam logic [OP_W-1:0] OP_SUB = 5'd9;
    localparam logic [OP_W-1:0] OP_GT  = 5'd10;
    localparam logic [OP_W-1:0] OP_GE  = 5'd11;
    localparam logic [OP_W-1:0] OP_LT  = 5'd12;
    localparam logic [OP_W-1:0] OP_LE  = 5'd13;
    localparam logic [OP_W-1:0] OP_EQ  = 5'd14;
    localparam logic [OP_W-1:0] OP_NE  = 5'd15;
    localparam logic [OP_W-1:0] OP_AND = 5'd16;
    localparam logic [OP_W-1:0] OP_OR  = 5'd17;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_MISSING  = 3'd1;
    localparam logic [ST_W-1:0] ST_LEFTOVER = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd4;
    localparam logic [ST_W-1:0] ST_DIVZERO  = 3'd5;

    // Request to and response from the divider.
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quotient;
        logic [WORD_W-1:0] remainder;
    } t_div_rsp;
endpackage
`default_nettype wire

@@ hdl/pse_if.sv @@
// Handshake interfaces for the token input and the result output.
// Depends on pse_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface pse_tok_if import pse_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            kind;
    logic [NUM_W-1:0] number_value;
    logic [OP_W-1:0] op_code;
    logic            last;
    modport source (output valid, kind, number_value, op_code, last, input ready);
    modport sink (input valid, kind, number_value, op_code, last, output ready);
endinterface

interface pse_res_if import pse_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] answer;
    logic [ST_W-1:0]          status;
    modport source (output valid, answer, status, input ready);
    modport sink (input valid, answer, status, output ready);
endinterface
`default_nettype wire

@@ hdl/pse_div.sv @@
// Signed 32-bit restoring divider, one quotient bit per cycle.
// Depends on pse_pkg; instantiated by the top level.
`timescale 1ns / 1ps
`default_nettype none
module pse_div import pse_pkg::*; (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int CNT_W = $clog2(WORD_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_quo;
    logic [WORD_W-1:0] r_dvs;
    logic              r_qneg;
    logic              r_rneg;

    logic [WORD_W:0]   w_diff;
    logic [WORD_W-1:0] w_mag_a;
    logic [WORD_W-1:0] w_mag_b;

    // Magnitudes of the operands at start.
    assign w_mag_a = i_req.dividend[WORD_W-1] ? (~i_req.dividend + 1'b1) : i_req.dividend;
    assign w_mag_b = i_req.divisor[WORD_W-1] ? (~i_req.divisor + 1'b1) : i_req.divisor;

    // Trial subtraction of the shifted partial remainder.
    assign w_diff = {r_rem, r_quo[WORD_W-1]} - {1'b0, r_dvs};

    // Control: busy until every quotient bit is produced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WORD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out of the quotient register as bits enter.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_quo  <= w_mag_a;
            r_dvs  <= w_mag_b;
            r_qneg <= i_req.dividend[WORD_W-1] ^ i_req.divisor[WORD_W-1];
            r_rneg <= i_req.dividend[WORD_W-1];
        end else if (r_busy) begin
            r_rem <= w_diff[WORD_W] ? {r_rem[WORD_W-2:0], r_quo[WORD_W-1]} : w_diff[WORD_W-1:0];
            r_quo <= {r_quo[WORD_W-2:0], ~w_diff[WORD_W]};
        end
    end

    // Sign correction: the quotient follows the operand signs, the remainder the dividend.
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_qneg ? (~r_quo + 1'b1) : r_quo;
    assign o_rsp.remainder = r_rneg ? (~r_rem + 1'b1) : r_rem;
endmodule
`default_nettype wire

@@ hdl/postfix_stack_evaluator.sv @@
// Top level of the postfix stack evaluator: sequencer, operand stack, shared multiplier.
// Depends on pse_pkg, pse_if, pse_div and postfix_stack_evaluator_defines.svh.
//
// Channel   Dir  Words        Fields
// i_tok     in   one token    kind, number_value, op_code, last
// o_res     out  one result   answer, status (only after a last token)
//
// A push passes through decode and done; an operator also reads and executes before
// done writes its result back. Multiply adds the multiply state; divide and remainder
// wait in the divide state, one quotient bit per cycle in the divider. Power makes two
// passes through the one shared multiplier per exponent bit.
// The block takes one word at a time; a result waits in the output register and
// a later last token stalls only until that register is free.
// Reset is synchronous and active low; stack contents are not cleared.
`include "postfix_stack_evaluator_defines.svh"
`timescale 1ns / 1ps
`default_nettype none
module postfix_stack_evaluator import pse_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    pse_tok_if.sink     i_tok,
    pse_res_if.source   o_res
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_READ   = 9'b000000100,
        S_EXEC   = 9'b000001000,
        S_MUL    = 9'b000010000,
        S_POW    = 9'b000100000,
        S_PSQ    = 9'b001000000,
        S_DIV    = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [WORD_W-1:0] r_mem [STACK_DEPTH];
    logic [CW-1:0]     r_cnt;
    logic [ST_W-1:0]   r_err;
    logic              r_kind;
    logic [NUM_W-1:0]  r_num;
    logic [OP_W-1:0]   r_op;
    logic              r_last;
    logic [WORD_W-1:0] r_rhs;
    logic [WORD_W-1:0] r_lhs;
    logic [WORD_W-1:0] r_acc;
    logic [WORD_W-1:0] r_base;
    logic [WORD_W-1:0] r_ex;
    logic [WORD_W-1:0] r_bottom;
    logic              r_push;
    logic [WORD_W-1:0] r_res;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_answer;
    logic [ST_W-1:0]   r_out_status;

    logic              w_wr_en;
    logic [WORD_W-1:0] w_wr_data;
    logic [WORD_W-1:0] w_ma, w_mb, w_prod;
    logic [WORD_W-1:0] w_simple;
    logic              w_unary;
    logic              w_out_free;
    logic              w_out_load;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;

    assign i_tok.ready  = (r_state == S_IDLE);
    assign w_out_free   = !r_out_valid || o_res.ready;
    assign w_out_load   = (r_state == S_DONE) && !r_push && r_last && w_out_free;
    assign w_unary      = (r_op <= OP_NEG);
    assign o_res.valid  = r_out_valid;
    assign o_res.answer = r_out_answer;
    assign o_res.status = r_out_status;

    // Shared multiplier: operands are chosen by the sequencer state.
    always_comb begin
        unique case (r_state)
            S_POW:   begin w_ma = r_acc;  w_mb = r_base; end
            S_PSQ:   begin w_ma = r_base; w_mb = r_base; end
            default: begin w_ma = r_lhs;  w_mb = r_rhs;  end
        endcase
    end
    assign w_prod = WORD_W'(w_ma * w_mb);

    // Combinational results of the one-step operators.
    always_comb begin
        case (r_op)
            OP_NOT:  w_simple = WORD_W'(r_rhs == '0);
            OP_INC:  w_simple = r_rhs + 1'b1;
            OP_DEC:  w_simple = r_rhs - 1'b1;
            OP_NEG:  w_simple = '0 - r_rhs;
            OP_ADD:  w_simple = r_lhs + r_rhs;
            OP_SUB:  w_simple = r_lhs - r_rhs;
            OP_GT:   w_simple = WORD_W'($signed(r_lhs) > $signed(r_rhs));
            OP_GE:   w_simple = WORD_W'($signed(r_lhs) >= $signed(r_rhs));
            OP_LT:   w_simple = WORD_W'($signed(r_lhs) < $signed(r_rhs));
            OP_LE:   w_simple = WORD_W'($signed(r_lhs) <= $signed(r_rhs));
            OP_EQ:   w_simple = WORD_W'(r_lhs == r_rhs);
            OP_NE:   w_simple = WORD_W'(r_lhs != r_rhs);
            OP_AND:  w_simple = WORD_W'((r_lhs != '0) && (r_rhs != '0));
            default: w_simple = WORD_W'((r_lhs != '0) || (r_rhs != '0));
        endcase
    end

    // Divider start and stack write strobes.
    assign w_div_req.start    = (r_state == S_EXEC) && ((r_op == OP_DIV) || (r_op == OP_REM))
                                && (r_rhs != '0);
    assign w_div_req.dividend = r_lhs;
    assign w_div_req.divisor  = r_rhs;
    assign w_wr_en   = ((r_state == S_DECODE) && (r_err == ST_OK) && !r_kind
                        && (r_cnt < CW'(STACK_DEPTH))) || ((r_state == S_DONE) && r_push);
    assign w_wr_data = (r_state == S_DECODE) ? {1'b0, r_num} : r_res;

    pse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Stack memory: one write port, two registered read ports.
    // Both operands are read once while decoding and then hold for the operator.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_cnt[AW-1:0]] <= w_wr_data;
        end
        if (r_state == S_DECODE) begin
            r_rhs <= r_mem[AW'(r_cnt - 1'b1)];
            r_lhs <= r_mem[AW'(r_cnt - CW'(2))];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_tok.valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if ((r_err != ST_OK) || !r_kind || (r_op > OP_OR)) begin
                    n_state = S_DONE;
                end else if (r_cnt < (w_unary ? CW'(1) : CW'(2))) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: begin
                if (r_op == OP_MUL) begin
                    n_state = S_MUL;
                end else if (r_op == OP_POW) begin
                    n_state = r_rhs[WORD_W-1] ? S_DONE : S_POW;
                end else if (w_div_req.start) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL: n_state = S_DONE;
            S_POW: n_state = (r_ex == '0) ? S_DONE : S_PSQ;
            S_PSQ: n_state = S_POW;
            S_DIV: begin
                if (w_div_rsp.done) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_push && (!r_last || w_out_free)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer registers and stack pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_err       <= ST_OK;
            r_push      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // The output word is loaded on a last token and dropped once taken.
            if (w_out_load) r_out_valid <= 1'b1;
            else if (o_res.ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_DECODE: begin
                    if (r_err == ST_OK) begin
                        if (!r_kind) begin
                            if (r_cnt < CW'(STACK_DEPTH)) begin
                                r_cnt <= r_cnt + 1'b1;
                            end else begin
                                r_err <= ST_OVERFLOW;
                            end
                        end else if (r_op <= OP_OR) begin
                            if (r_cnt < (w_unary ? CW'(1) : CW'(2))) r_err <= ST_MISSING;
                        end
                    end
                end
                S_READ: r_cnt <= r_cnt - (w_unary ? CW'(1) : CW'(2));
                S_EXEC: begin
                    if (((r_op == OP_DIV) || (r_op == OP_REM)) && (r_rhs == '0)) begin
                        r_err <= ST_DIVZERO;
                    end else if ((r_op == OP_POW) && r_rhs[WORD_W-1]) begin
                        if (r_lhs == '0) r_err <= ST_DIVZERO;
                        else r_push <= 1'b1;
                    end else if ((r_op != OP_MUL) && (r_op != OP_POW)
                                 && !w_div_req.start) begin
                        r_push <= 1'b1;
                    end
                end
                S_MUL: r_push <= 1'b1;
                S_POW: begin
                    if (r_ex == '0) r_push <= 1'b1;
                end
                S_DIV: begin
                    if (w_div_rsp.done) r_push <= 1'b1;
                end
                S_DONE: begin
                    if (r_push) begin
                        r_push <= 1'b0;
                        r_cnt  <= r_cnt + 1'b1;
                    end else if (r_last && w_out_free) begin
                        r_cnt <= '0;
                        r_err <= ST_OK;
                    end
                end
                default: ;
            endcase
        end
    end

    // Token capture, operator results and the output word.
    always_ff @(posedge i_clk) begin
        if (i_tok.valid && i_tok.ready) begin
            r_kind <= i_tok.kind;
            r_num  <= i_tok.number_value;
            r_op   <= i_tok.op_code;
            r_last <= i_tok.last;
        end
        if (w_wr_en && (r_cnt == '0)) r_bottom <= w_wr_data;
        unique case (r_state)
            S_EXEC: begin
                r_acc  <= WORD_W'(1);
                r_base <= r_lhs;
                r_ex   <= r_rhs;
                // Negative exponent: only bases one and minus one survive truncation.
                if (r_op == OP_POW) begin
                    if (r_lhs == WORD_W'(1)) r_res <= WORD_W'(1);
                    else if (r_lhs == '1) r_res <= r_rhs[0] ? '1 : WORD_W'(1);
                    else r_res <= '0;
                end else begin
                    r_res <= w_simple;
                end
            end
            S_MUL: r_res <= w_prod;
            S_POW: begin
                if (r_ex == '0) r_res <= r_acc;
                else if (r_ex[0]) r_acc <= w_prod;
            end
            S_PSQ: begin
                r_base <= w_prod;
                r_ex   <= r_ex >> 1;
            end
            S_DIV: r_res <= (r_op == OP_DIV) ? w_div_rsp.quotient : w_div_rsp.remainder;
            S_DONE: begin
                if (w_out_load) begin
                    if (r_err != ST_OK) begin
                        r_out_status <= r_err;
                        r_out_answer <= '0;
                    end else if (r_cnt == '0) begin
                        r_out_status <= ST_EMPTY;
                        r_out_answer <= '0;
                    end else if (r_cnt > CW'(1)) begin
                        r_out_status <= ST_LEFTOVER;
                        r_out_answer <= '0;
                    end else begin
                        r_out_status <= ST_OK;
                        r_out_answer <= r_bottom;
                    end
                end
            end
            default: ;
        endcase
    end

    // Assertions.
    `PSE_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(STACK_DEPTH), "stack count past depth")
    `PSE_ASSERT(a_err_answer, i_clk, i_rst_n, !o_res.valid || (o_res.status == ST_OK) || (o_res.answer == '0), "error result with nonzero answer")
    `PSE_ASSERT_NEXT(a_one_token, i_clk, i_rst_n, i_tok.valid && i_tok.ready, !i_tok.ready, "token taken while busy")
    `PSE_ASSERT_NEXT(a_div_done, i_clk, i_rst_n, w_div_req.start, !w_div_rsp.done, "divider finished at once")
endmodule
`default_nettype wire

@@ tb/postfix_stack_evaluator_tb.sv @@
// Self-checking bench for the postfix stack evaluator: directed rows and sequences, then random expressions.
// Depends on pse_pkg, pse_if and the evaluator RTL.
`timescale 1ns / 1ps
`default_nettype none
module postfix_stack_evaluator_tb;
    import pse_pkg::*;

    localparam int DEPTH = STACK_DEPTH_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam logic [ST_W-1:0] ST_UNTYPED = 3'h7;
    localparam logic [OP_W-1:0] OP_UNUSED = 5'd20;

    typedef struct {
        logic             kind;
        logic [NUM_W-1:0] num;
        logic [OP_W-1:0]  op;
        logic             last;
        logic             has_exp;
        logic [WORD_W-1:0] exp_answer;
        logic [ST_W-1:0]  exp_status;
    } t_row;

    typedef struct {
        logic [WORD_W-1:0] answer;
        logic [ST_W-1:0]   status;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pse_tok_if tok_bus ();
    pse_res_if res_bus ();

    postfix_stack_evaluator u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tok  (tok_bus.sink),
        .o_res  (res_bus.source)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state of the evaluator.
    logic [WORD_W-1:0] calc_stack [DEPTH];
    int unsigned calc_depth;
    logic [ST_W-1:0] calc_err;

    t_outcome pending_answers[$];
    t_outcome typed_answers[$];
    int unsigned fail_count = 0;
    int unsigned words_sent = 0;
    int unsigned answers_seen = 0;
    int unsigned idle_cycles = 0;
    logic feed_done = 1'b0;

    // Power with wrap at 32 bits; a negative exponent truncates the real result.
    function automatic logic [WORD_W-1:0] raise_power(logic [WORD_W-1:0] base,
                                                     logic [WORD_W-1:0] ex);
        logic [WORD_W-1:0] acc;
        acc = WORD_W'(1);
        if (ex[WORD_W-1]) begin
            if (base == WORD_W'(1)) return WORD_W'(1);
            if (base == '1) return ex[0] ? '1 : WORD_W'(1);
            if (base == '0) calc_err = ST_DIVZERO;
            return '0;
        end
        while (ex != '0) begin
            if (ex[0]) acc = acc * base;
            base = base * base;
            ex = ex >> 1;
        end
        return acc;
    endfunction

    // Applies one operator to the predicted stack.
    function automatic void apply_operator(logic [OP_W-1:0] op);
        logic [WORD_W-1:0] lhs, rhs, r;
        logic signed [WORD_W-1:0] sl, sr;
        lhs = '0;
        r = '0;
        if (op > OP_OR) return;
        if (op <= OP_NEG) begin
            if (calc_depth < 1) begin calc_err = ST_MISSING; return; end
            rhs = calc_stack[calc_depth-1];
            calc_depth -= 1;
        end else begin
            if (calc_depth < 2) begin calc_err = ST_MISSING; return; end
            rhs = calc_stack[calc_depth-1];
            lhs = calc_stack[calc_depth-2];
            calc_depth -= 2;
        end
        sl = lhs;
        sr = rhs;
        case (op)
            OP_NOT: r = WORD_W'(rhs == '0);
            OP_INC: r = rhs + WORD_W'(1);
            OP_DEC: r = rhs - WORD_W'(1);
            OP_NEG: r = '0 - rhs;
            OP_POW: r = raise_power(lhs, rhs);
            OP_MUL: r = lhs * rhs;
            OP_DIV, OP_REM: begin
                if (rhs == '0) begin calc_err = ST_DIVZERO; return; end
                if (lhs == 32'h8000_0000 && rhs == '1)
                    r = (op == OP_DIV) ? 32'h8000_0000 : '0;
                else if (op == OP_DIV)
                    r = sl / sr;
                else
                    r = sl % sr;
            end
            OP_ADD: r = lhs + rhs;
            OP_SUB: r = lhs - rhs;
            OP_GT:  r = WORD_W'(sl > sr);
            OP_GE:  r = WORD_W'(sl >= sr);
            OP_LT:  r = WORD_W'(sl < sr);
            OP_LE:  r = WORD_W'(sl <= sr);
            OP_EQ:  r = WORD_W'(lhs == rhs);
            OP_NE:  r = WORD_W'(lhs != rhs);
            OP_AND: r = WORD_W'(lhs != '0 && rhs != '0);
            default: r = WORD_W'(lhs != '0 || rhs != '0);
        endcase
        if (calc_err != ST_OK) return;
        calc_stack[calc_depth] = r;
        calc_depth += 1;
    endfunction

    // Advances the predictor by one word and queues the answer on a last word.
    function automatic void predict_word(logic kind, logic [NUM_W-1:0] num,
                                         logic [OP_W-1:0] op, logic last);
        t_outcome o;
        if (calc_err == ST_OK) begin
            if (!kind) begin
                if (calc_depth >= DEPTH) calc_err = ST_OVERFLOW;
                else begin
                    calc_stack[calc_depth] = {1'b0, num};
                    calc_depth += 1;
                end
            end else begin
                apply_operator(op);
            end
        end
        if (!last) return;
        o.answer = '0;
        o.status = calc_err;
        if (calc_err == ST_OK) begin
            if (calc_depth == 0) o.status = ST_EMPTY;
            else if (calc_depth > 1) o.status = ST_LEFTOVER;
            else o.answer = calc_stack[0];
        end
        pending_answers.insert(pending_answers.size(), o);
        calc_depth = 0;
        calc_err = ST_OK;
    endfunction

    function automatic int unsigned gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Sends one word and waits for it to be taken; valid drops only for a gap.
    task automatic send_word(logic kind, logic [NUM_W-1:0] num, logic [OP_W-1:0] op,
                             logic last, logic burst);
        int unsigned gap;
        gap = burst ? 0 : gap_len();
        if (gap != 0) begin
            tok_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tok_bus.valid <= 1'b1;
        tok_bus.kind <= kind;
        tok_bus.number_value <= num;
        tok_bus.op_code <= op;
        tok_bus.last <= last;
        predict_word(kind, num, op, last);
        words_sent++;
        @(posedge i_clk);
        while (!tok_bus.ready) @(posedge i_clk);
    endtask

    // Random operand; biased toward small and boundary values.
    function automatic logic [NUM_W-1:0] pick_number();
        case ($urandom_range(0, 5))
            0: return NUM_W'($urandom_range(0, 3));
            1: return {NUM_W{1'b1}};
            2: return NUM_W'($urandom_range(0, 40));
            default: return NUM_W'($urandom);
        endcase
    endfunction

    // Builds a mostly well-formed expression and sends it.
    task automatic send_expression(logic burst);
        int unsigned words, depth;
        logic [OP_W-1:0] op;
        logic kind;
        words = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 8);
        depth = 0;
        for (int unsigned i = 0; i < words; i++) begin
            if ($urandom_range(0, 9) == 0) kind = 1'($urandom_range(0, 1));
            else kind = (depth < 2) ? 1'b0 : ($urandom_range(0, 1) == 1);
            op = ($urandom_range(0, 29) == 0) ? OP_W'($urandom_range(18, 31))
                                              : OP_W'($urandom_range(0, 17));
            if (kind) depth = (op <= OP_NEG) ? depth : (depth > 0 ? depth - 1 : 0);
            else depth++;
            send_word(kind, pick_number(), op, i == words - 1, burst);
        end
    endtask

    // Result side: random backpressure and comparison with the predictor.
    initial begin
        t_outcome want;
        res_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_bus.valid && res_bus.ready) begin
                answers_seen++;
                if (pending_answers.size() == 0) begin
                    $error("unexpected result answer=%0h status=%0d",
                           res_bus.answer, res_bus.status);
                    fail_count++;
                end else begin
                    want = pending_answers.pop_front();
                    if (res_bus.answer !== want.answer) begin
                        $error("answer: expected %0h, got %0h", want.answer, res_bus.answer);
                        fail_count++;
                    end
                    if (res_bus.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, res_bus.status);
                        fail_count++;
                    end
                    if (typed_answers.size() != 0) begin
                        want = typed_answers.pop_front();
                        if (want.status != ST_UNTYPED && (res_bus.answer !== want.answer ||
                                res_bus.status !== want.status)) begin
                            $error("typed row: expected %0h/%0d, got %0h/%0d",
                                   want.answer, want.status, res_bus.answer, res_bus.status);
                            fail_count++;
                        end
                    end
                end
            end
            res_bus.ready <= (gap_len() == 0);
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge i_clk) begin
        if ((tok_bus.valid && tok_bus.ready) || (res_bus.valid && res_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Directed rows: kind, number, op, last, typed check, answer, status.
    t_row rows[$];
    function automatic void add_row(logic k, logic [NUM_W-1:0] n, logic [OP_W-1:0] op,
                                    logic l, logic h = 1'b0, logic [WORD_W-1:0] a = '0,
                                    logic [ST_W-1:0] s = ST_OK);
        t_row r;
        r = '{k, n, op, l, h, a, s};
        rows.insert(rows.size(), r);
    endfunction

    initial begin
        t_outcome t;
        tok_bus.valid = 1'b0;
        tok_bus.kind = 1'b0;
        tok_bus.number_value = '0;
        tok_bus.op_code = OP_NOT;
        tok_bus.last = 1'b0;
        calc_depth = 0;
        calc_err = ST_OK;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty expression, largest literal, missing operand.
        add_row(1'b1, '0, OP_UNUSED, 1'b1, 1'b1, '0, ST_EMPTY);
        add_row(1'b0, {NUM_W{1'b1}}, OP_NOT, 1'b1, 1'b1, 32'h7fff_ffff, ST_OK);
        add_row(1'b1, '0, OP_ADD, 1'b1, 1'b1, '0, ST_MISSING);
        add_row(1'b1, '0, OP_NOT, 1'b1, 1'b1, '0, ST_MISSING);
        // Leftover operands.
        add_row(1'b0, 31'd0, OP_NOT, 1'b0);
        add_row(1'b0, 31'd1, OP_NOT, 1'b1, 1'b1, '0, ST_LEFTOVER);
        // Divide by zero, then sticky error.
        add_row(1'b0, 31'd7, OP_NOT, 1'b0);
        add_row(1'b0, 31'd0, OP_NOT, 1'b0);
        add_row(1'b1, '0, OP_DIV, 1'b0);
        add_row(1'b0, 31'd3, OP_NOT, 1'b1, 1'b1, '0, ST_DIVZERO);
        // Most negative over minus one: 0 - max - 1 over 0 - 1.
        add_row(1'b0, {NUM_W{1'b1}}, OP_NOT, 1'b0);
        add_row(1'b1, '0, OP_NEG, 1'b0);
        add_row(1'b1, '0, OP_DEC, 1'b0);
        add_row(1'b0, 31'd1, OP_NOT, 1'b0);
        add_row(1'b1, '0, OP_NEG, 1'b0);
        add_row(1'b1, '0, OP_DIV, 1'b1, 1'b1, 32'h8000_0000, ST_OK);
        // Zero to a negative power, and zero to the zero.
        add_row(1'b0, 31'd0, OP_NOT, 1'b0);
        add_row(1'b0, 31'd1, OP_NOT, 1'b0);
        add_row(1'b1, '0, OP_NEG, 1'b0);
        add_row(1'b1, '0, OP_POW, 1'b1, 1'b1, '0, ST_DIVZERO);
        add_row(1'b0, 31'd0, OP_NOT, 1'b0);
        add_row(1'b0, 31'd0, OP_NOT, 1'b0);
        add_row(1'b1, '0, OP_POW, 1'b1, 1'b1, 32'd1, ST_OK);
        foreach (rows[i]) begin
            if (rows[i].last) begin
                t.answer = rows[i].exp_answer;
                t.status = rows[i].has_exp ? rows[i].exp_status : ST_UNTYPED;
                typed_answers.insert(typed_answers.size(), t);
            end
            send_word(rows[i].kind, rows[i].num, rows[i].op, rows[i].last, 1'b0);
        end

        // Overflow: seventeen pushes in a row.
        for (int i = 0; i <= DEPTH; i++)
            send_word(1'b0, NUM_W'(i), OP_NOT, i == DEPTH, 1'b1);
        // Every operator once on random operands.
        for (int op = OP_NOT; op <= OP_OR; op++) begin
            send_word(1'b0, NUM_W'($urandom), OP_NOT, 1'b0, 1'b0);
            send_word(1'b0, NUM_W'($urandom_range(0, 5)), OP_NOT, 1'b0, 1'b0);
            send_word(1'b1, '0, OP_W'(op), 1'b0, 1'b0);
            send_word(1'b1, '0, OP_ADD, 1'b1, 1'b0);
        end

        // Random expressions, with some bursts of back-to-back words.
        while (words_sent < 1200) send_expression($urandom_range(0, 4) == 0);
        tok_bus.valid <= 1'b0;
        feed_done = 1'b1;

        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d words; checked %0d results across all operators and statuses.",
                 words_sent, answers_seen);
        if (fail_count == 0 && pending_answers.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
